[hdl/sed_pkg.sv]
`timescale 1ns / 1ps
// Package for the Sobel edge detector: payload structs, command word, state codes.
// Used by every module of the block except sed_ram; depends on nothing.
package sed_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int ROW_W       = 12;
    localparam int WREG_W      = 11;
    localparam int HREG_W      = 13;
    localparam int CFG_W       = 13;
    localparam int MAX_HEIGHT  = 4096;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = 1;

    localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
    localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);

    localparam logic [15:0] COEF_R = 16'd19595;
    localparam logic [15:0] COEF_G = 16'd38470;
    localparam logic [15:0] COEF_B = 16'd7471;

    localparam logic       OP_PIXEL   = 1'b0;
    localparam logic       OP_FLUSH   = 1'b1;
    localparam logic [0:0] REG_WIDTH  = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic       opcode;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } sed_in_t;

    typedef struct packed {
        logic [7:0]       edge_value;
        logic [COL_W-1:0] out_col;
        logic [ROW_W-1:0] out_row;
        logic             frame_last;
    } sed_out_t;

    typedef enum logic {
        CMD_PIXEL,
        CMD_DRAIN
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             emit_a;
        logic             use_sobel;
        logic             emit_b;
        logic             last;
    } sed_cmd_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_LUMA,
        BK_GRAD,
        BK_SQUARE,
        BK_SUM,
        BK_ROOT,
        BK_DRAIN,
        BK_EMIT_A,
        BK_EMIT_B,
        BK_EMIT_D
    } back_state_t;

endpackage

[hdl/sed_ram.sv]
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data.
// No dependencies.
module sed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata <= mem_reg[addr];
    end

endmodule

[hdl/sed_front.sv]
`timescale 1ns / 1ps
// Front end: geometry registers, raster position tracking and command classification.
// Depends on sed_pkg.
module sed_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [0:0]                   cfg_index,
    input  logic [sed_pkg::CFG_W-1:0]    cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  sed_pkg::sed_in_t             s_data,
    input  logic                         q_full,
    output logic                         q_push,
    output sed_pkg::sed_cmd_t            q_data
);

    logic [sed_pkg::WREG_W-1:0] width_reg, width_next;
    logic [sed_pkg::HREG_W-1:0] height_reg, height_next;
    logic [sed_pkg::COL_W-1:0]  col_reg, col_next;
    logic [sed_pkg::ROW_W-1:0]  row_reg, row_next;
    logic [sed_pkg::COL_W-1:0]  dcol_reg, dcol_next;
    logic                       draining_reg, draining_next;
    logic [sed_pkg::WREG_W-1:0] eff_w;
    logic [sed_pkg::HREG_W-1:0] eff_h;
    logic                       col_last, row_last, dcol_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= sed_pkg::WIDTH_RESET;
            height_reg   <= sed_pkg::HEIGHT_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            dcol_reg     <= '0;
            draining_reg <= 1'b0;
        end else begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            dcol_reg     <= dcol_next;
            draining_reg <= draining_next;
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            eff_w = sed_pkg::WREG_W'(1);
        end else if (width_reg > sed_pkg::WREG_W'(sed_pkg::MAX_WIDTH)) begin
            eff_w = sed_pkg::WREG_W'(sed_pkg::MAX_WIDTH);
        end else begin
            eff_w = width_reg;
        end
        if (height_reg == '0) begin
            eff_h = sed_pkg::HREG_W'(1);
        end else if (height_reg > sed_pkg::HREG_W'(sed_pkg::MAX_HEIGHT)) begin
            eff_h = sed_pkg::HREG_W'(sed_pkg::MAX_HEIGHT);
        end else begin
            eff_h = height_reg;
        end
    end

    assign col_last  = ({1'b0, col_reg} + sed_pkg::WREG_W'(1)) >= eff_w;
    assign dcol_last = ({1'b0, dcol_reg} + sed_pkg::WREG_W'(1)) >= eff_w;
    assign row_last  = ({1'b0, row_reg} + sed_pkg::HREG_W'(1)) >= eff_h;
    assign s_ready   = !q_full;

    always_comb begin
        width_next    = width_reg;
        height_next   = height_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        dcol_next     = dcol_reg;
        draining_next = draining_reg;
        q_push        = 1'b0;
        q_data        = '0;
        q_data.red    = s_data.red;
        q_data.green  = s_data.green;
        q_data.blue   = s_data.blue;
        if (cfg_we) begin
            if (cfg_index == sed_pkg::REG_WIDTH) begin
                width_next = cfg_wdata[sed_pkg::WREG_W-1:0];
            end else begin
                height_next = cfg_wdata[sed_pkg::HREG_W-1:0];
            end
            col_next      = '0;
            row_next      = '0;
            dcol_next     = '0;
            draining_next = 1'b0;
        end else if (s_valid && s_ready) begin
            if (s_data.opcode == sed_pkg::OP_FLUSH) begin
                if (draining_reg) begin
                    q_push       = 1'b1;
                    q_data.kind  = sed_pkg::CMD_DRAIN;
                    q_data.col   = dcol_reg;
                    q_data.row   = sed_pkg::ROW_W'(eff_h - sed_pkg::HREG_W'(1));
                    q_data.last  = dcol_last;
                    if (dcol_last) begin
                        draining_next = 1'b0;
                        dcol_next     = '0;
                    end else begin
                        dcol_next = dcol_reg + sed_pkg::COL_W'(1);
                    end
                end
            end else if (!draining_reg) begin
                q_push           = 1'b1;
                q_data.kind      = sed_pkg::CMD_PIXEL;
                q_data.col       = col_reg;
                q_data.row       = row_reg;
                q_data.emit_a    = (row_reg != '0) && (col_reg != '0);
                q_data.use_sobel = (row_reg > sed_pkg::ROW_W'(1)) &&
                                   (col_reg > sed_pkg::COL_W'(1));
                q_data.emit_b    = (row_reg != '0) && col_last;
                if (col_last) begin
                    col_next = '0;
                    if (row_last) begin
                        row_next      = '0;
                        draining_next = 1'b1;
                        dcol_next     = '0;
                    end else begin
                        row_next = row_reg + sed_pkg::ROW_W'(1);
                    end
                end else begin
                    col_next = col_reg + sed_pkg::COL_W'(1);
                end
            end
        end
    end

endmodule

[hdl/sed_queue.sv]
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
// Depends on sed_pkg.
module sed_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  sed_pkg::sed_cmd_t push_data,
    output logic              full,
    input  logic              pop,
    output sed_pkg::sed_cmd_t head,
    output logic              empty
);

    sed_pkg::sed_cmd_t                entry_reg [sed_pkg::QUEUE_DEPTH];
    logic [sed_pkg::QUEUE_AW-1:0]     wptr_reg, wptr_next;
    logic [sed_pkg::QUEUE_AW-1:0]     rptr_reg, rptr_next;
    logic [sed_pkg::QUEUE_AW:0]       count_reg, count_next;

    assign full  = count_reg == (sed_pkg::QUEUE_AW+1)'(sed_pkg::QUEUE_DEPTH);
    assign empty = count_reg == '0;
    assign head  = entry_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_data;
        end
    end

    always_comb begin
        wptr_next  = push ? wptr_reg + sed_pkg::QUEUE_AW'(1) : wptr_reg;
        rptr_next  = pop ? rptr_reg + sed_pkg::QUEUE_AW'(1) : rptr_reg;
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (sed_pkg::QUEUE_AW+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (sed_pkg::QUEUE_AW+1)'(1);
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (sed_pkg::QUEUE_AW+1)'(sed_pkg::QUEUE_DEPTH))
        else $error("Queue count exceeds its depth.");

    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("Word pushed into a full queue.");

    assert property (@(posedge aclk) disable iff (!aresetn) pop |-> !empty)
        else $error("Word popped from an empty queue.");

endmodule

[hdl/sed_back.sv]
`timescale 1ns / 1ps
// Back end: luma, row stores, 3x3 window, Sobel gradient, iterative square root, output register.
// Depends on sed_pkg and sed_ram.
module sed_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  sed_pkg::sed_cmd_t q_head,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output sed_pkg::sed_out_t m_data
);

    localparam logic [23:0] COEF_R_24 = {8'b0, sed_pkg::COEF_R};
    localparam logic [23:0] COEF_G_24 = {8'b0, sed_pkg::COEF_G};
    localparam logic [23:0] COEF_B_24 = {8'b0, sed_pkg::COEF_B};

    sed_pkg::back_state_t      state_reg, state_next;
    sed_pkg::sed_cmd_t         cmd_reg, cmd_next;
    logic [7:0]                win_reg [3][3];
    logic [7:0]                win_next [3][3];
    logic [23:0]               prod_r_reg, prod_g_reg, prod_b_reg;
    logic [24:0]               luma_sum;
    logic [7:0]                luma;
    logic [7:0]                val_reg, val_next;
    logic [7:0]                mval_reg, mval_next;
    logic [9:0]                ax_reg, ax_next, ay_reg, ay_next;
    logic [19:0]               sqx_reg, sqy_reg;
    logic [20:0]               sq_sum;
    logic [15:0]               rad_reg, rad_next;
    logic [7:0]                root_reg, root_next;
    logic [7:0]                bit_reg, bit_next;
    logic [7:0]                trial;
    logic                      m_valid_reg, m_valid_next;
    sed_pkg::sed_out_t         m_data_reg, m_data_next;
    logic                      out_free;
    logic                      ram_we;
    logic [sed_pkg::COL_W-1:0] ram_addr;
    logic [7:0]                up_rdata, mid_rdata;
    logic [10:0]               gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [10:0]        gx, gy;

    sed_ram #(.WIDTH(8), .DEPTH(sed_pkg::MAX_WIDTH)) u_upper (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (mid_rdata),
        .rdata (up_rdata)
    );

    sed_ram #(.WIDTH(8), .DEPTH(sed_pkg::MAX_WIDTH)) u_middle (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (luma),
        .rdata (mid_rdata)
    );

    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign ram_we   = state_reg == sed_pkg::BK_LUMA;
    assign ram_addr = (state_reg == sed_pkg::BK_IDLE) ? q_head.col : cmd_reg.col;

    assign luma_sum = {1'b0, prod_r_reg} + {1'b0, prod_g_reg} + {1'b0, prod_b_reg};
    assign luma     = luma_sum[23:16];

    assign gx_pos = {3'b0, win_reg[0][2]} + {2'b0, win_reg[1][2], 1'b0} + {3'b0, win_reg[2][2]};
    assign gx_neg = {3'b0, win_reg[0][0]} + {2'b0, win_reg[1][0], 1'b0} + {3'b0, win_reg[2][0]};
    assign gy_pos = {3'b0, win_reg[2][0]} + {2'b0, win_reg[2][1], 1'b0} + {3'b0, win_reg[2][2]};
    assign gy_neg = {3'b0, win_reg[0][0]} + {2'b0, win_reg[0][1], 1'b0} + {3'b0, win_reg[0][2]};
    assign gx     = $signed(gx_pos - gx_neg);
    assign gy     = $signed(gy_pos - gy_neg);
    assign sq_sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};
    assign trial  = root_reg | bit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sed_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win_reg[i][j] <= '0;
                end
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            win_reg     <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        val_reg    <= val_next;
        mval_reg   <= mval_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        rad_reg    <= rad_next;
        root_reg   <= root_next;
        bit_reg    <= bit_next;
        m_data_reg <= m_data_next;
        prod_r_reg <= q_head.red * COEF_R_24;
        prod_g_reg <= q_head.green * COEF_G_24;
        prod_b_reg <= q_head.blue * COEF_B_24;
        sqx_reg    <= ax_reg * ax_reg;
        sqy_reg    <= ay_reg * ay_reg;
    end

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        win_next     = win_reg;
        val_next     = val_reg;
        mval_next    = mval_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        rad_next     = rad_reg;
        root_next    = root_reg;
        bit_next     = bit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        q_pop        = 1'b0;
        case (state_reg)
            sed_pkg::BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_head;
                    state_next = (q_head.kind == sed_pkg::CMD_DRAIN) ?
                                 sed_pkg::BK_DRAIN : sed_pkg::BK_LUMA;
                end
            end
            sed_pkg::BK_LUMA: begin
                for (int i = 0; i < 3; i++) begin
                    win_next[i][0] = win_reg[i][1];
                    win_next[i][1] = win_reg[i][2];
                end
                win_next[0][2] = up_rdata;
                win_next[1][2] = mid_rdata;
                win_next[2][2] = luma;
                mval_next      = mid_rdata;
                val_next       = win_reg[1][2];
                if (cmd_reg.emit_a && cmd_reg.use_sobel) begin
                    state_next = sed_pkg::BK_GRAD;
                end else if (cmd_reg.emit_a) begin
                    state_next = sed_pkg::BK_EMIT_A;
                end else if (cmd_reg.emit_b) begin
                    state_next = sed_pkg::BK_EMIT_B;
                end else begin
                    state_next = sed_pkg::BK_IDLE;
                end
            end
            sed_pkg::BK_GRAD: begin
                ax_next    = gx[10] ? 10'(-gx) : gx[9:0];
                ay_next    = gy[10] ? 10'(-gy) : gy[9:0];
                state_next = sed_pkg::BK_SQUARE;
            end
            sed_pkg::BK_SQUARE: begin
                state_next = sed_pkg::BK_SUM;
            end
            sed_pkg::BK_SUM: begin
                if (sq_sum[20:16] != '0) begin
                    val_next   = 8'd255;
                    state_next = sed_pkg::BK_EMIT_A;
                end else begin
                    rad_next   = sq_sum[15:0];
                    root_next  = '0;
                    bit_next   = 8'h80;
                    state_next = sed_pkg::BK_ROOT;
                end
            end
            sed_pkg::BK_ROOT: begin
                if (trial * trial <= rad_reg) begin
                    root_next = trial;
                end
                bit_next = bit_reg >> 1;
                if (bit_reg[0]) begin
                    val_next   = root_next;
                    state_next = sed_pkg::BK_EMIT_A;
                end
            end
            sed_pkg::BK_DRAIN: begin
                val_next   = mid_rdata;
                state_next = sed_pkg::BK_EMIT_D;
            end
            sed_pkg::BK_EMIT_A: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.edge_value = val_reg;
                    m_data_next.out_col    = cmd_reg.col - sed_pkg::COL_W'(1);
                    m_data_next.out_row    = cmd_reg.row - sed_pkg::ROW_W'(1);
                    m_data_next.frame_last = 1'b0;
                    state_next = cmd_reg.emit_b ? sed_pkg::BK_EMIT_B : sed_pkg::BK_IDLE;
                end
            end
            sed_pkg::BK_EMIT_B: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.edge_value = mval_reg;
                    m_data_next.out_col    = cmd_reg.col;
                    m_data_next.out_row    = cmd_reg.row - sed_pkg::ROW_W'(1);
                    m_data_next.frame_last = 1'b0;
                    state_next             = sed_pkg::BK_IDLE;
                end
            end
            sed_pkg::BK_EMIT_D: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.edge_value = val_reg;
                    m_data_next.out_col    = cmd_reg.col;
                    m_data_next.out_row    = cmd_reg.row;
                    m_data_next.frame_last = cmd_reg.last;
                    state_next             = sed_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = sed_pkg::BK_IDLE;
            end
        endcase
    end

endmodule

[hdl/sobel_edge_detector.sv]
`timescale 1ns / 1ps
// A border or drain result passes IDLE, then LUMA or DRAIN, then an emit state, on its way to
// the output register; an interior result also passes GRAD, SQUARE and SUM, and then, unless
// it saturates, 8 root steps. The queue lets the front end accept words while the back end
// is busy with an earlier one, until the queue is full; the back-end sequencer sets the pace.
// Reset (aresetn low, synchronous) restores 640x480 geometry and clears position,
// queue and window; the row stores keep their contents and need no clearing pass.
module sobel_edge_detector (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [0:0]                cfg_index,
    input  logic [sed_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  sed_pkg::sed_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output sed_pkg::sed_out_t         m_data
);

    logic              q_full, q_push, q_pop, q_empty;
    sed_pkg::sed_cmd_t q_data, q_head;

    sed_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_data)
    );

    sed_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sed_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
